// ===== sv/drd_pkg.sv =====
`default_nettype none
package drd_pkg;

  localparam int CountWidth = 24;
  localparam int CapWidth   = 24;
  localparam int ValueW     = 32;
  localparam int RepW       = 9;
  localparam int QueueDepth = 4;

  localparam logic [CapWidth-1:0] CapReset = 24'd65536;
  localparam logic [ValueW-1:0]   OutWord  = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CAP   = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [RepW-1:0]          repeat_res;
    status_e                  status;
    logic                     end_of_stream;
  } res_t;

  // up to two result words per accepted byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

// ===== sv/drd_if.sv =====
`default_nettype none
interface drd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface drd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [8:0]         repeat_res;
  logic [1:0]         status;
  logic               end_of_stream;

  modport source (output valid, output value, output repeat_res, output status,
                  output end_of_stream, input ready);
  modport sink (input valid, input value, input repeat_res, input status,
                input end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== sv/drd_front.sv =====
`default_nettype none
module drd_front #(
  parameter int COUNT_WIDTH = drd_pkg::CountWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [drd_pkg::CapWidth-1:0]  cfg_wdata_i,
  input  wire                          room_i,
  drd_in_if.sink                       in_i,
  output drd_pkg::push_t               push_o
);
  import drd_pkg::*;

  localparam int SumW = (COUNT_WIDTH + 1 > CapWidth + 1) ? COUNT_WIDTH + 1 : CapWidth + 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COUNT,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    RT_OOR, RT_ZERO, RT_D4, RT_D8, RT_D12, RT_D16, RT_D24, RT_D32
  } rec_type_e;

  function automatic logic [31:0] sx4(input logic [3:0] c);
    sx4 = (c == 4'h8) ? '0 : {{28{c[3]}}, c};
  endfunction
  function automatic logic [31:0] sx8(input logic [7:0] c);
    sx8 = (c == 8'h80) ? '0 : {{24{c[7]}}, c};
  endfunction
  function automatic logic [31:0] sx12(input logic [11:0] c);
    sx12 = (c == 12'h800) ? '0 : {{20{c[11]}}, c};
  endfunction
  function automatic logic [31:0] sx16(input logic [15:0] c);
    sx16 = (c == 16'h8000) ? '0 : {{16{c[15]}}, c};
  endfunction
  function automatic logic [31:0] sx24(input logic [23:0] c);
    sx24 = (c == 24'h80_0000) ? '0 : {{8{c[23]}}, c};
  endfunction
  function automatic logic [4:0] nib5(input logic [3:0] c);
    nib5 = (c == 4'h8) ? '0 : {c[3], c};
  endfunction

  logic [31:0]            rv_q, rv_d;
  rec_type_e              rtype_q, rtype_d;
  logic [8:0]             left_q, left_d;
  phase_e                 phase_q, phase_d;
  logic [23:0]            gather_q, gather_d;
  logic [1:0]             gidx_q, gidx_d;
  logic [COUNT_WIDTH-1:0] words_q, words_d;
  logic                   halted_q, halted_d;
  logic [CapWidth-1:0]    cap_q, cap_d;

  logic        accept;
  logic [7:0]  b;
  logic [8:0]  cnt;
  rec_type_e   st_type;
  logic        start;
  logic [SumW-1:0] wsum;
  logic        over;
  logic        step1;
  logic [31:0] delta_a, sum_a, sum_b;
  logic        oor_a, oor_b;
  logic [4:0]  pair;
  logic [1:0]  need;
  logic [11:0] code12;
  logic [8:0]  left1;
  status_e     st;
  push_t       p;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid & room_i;
  assign b          = in_i.byte_in;

  assign cnt     = (phase_q == PH_COUNT) ? 9'd32 + {1'b0, b} : {4'd0, b[4:0]};
  assign st_type = (phase_q == PH_COUNT) ? rtype_q : rec_type_e'(b[7:5]);
  assign start   = (phase_q == PH_COUNT) || (phase_q == PH_HEADER && b[4:0] != 5'd0);
  assign wsum    = SumW'(words_q) + SumW'(cnt);
  assign over    = wsum > SumW'(cap_q);

  // running value after the first and, for 4-bit records, the second code
  assign pair   = nib5(b[3:0]) + nib5(b[7:4]);
  assign sum_a  = rv_q + delta_a;
  assign sum_b  = rv_q + {{27{pair[4]}}, pair};
  assign code12 = (gidx_q == 2'd1) ? {b[3:0], gather_q[7:0]} : {b, gather_q[15:12]};
  assign left1  = left_q - 9'd1;

  always_comb begin
    rv_d     = rv_q;
    rtype_d  = rtype_q;
    left_d   = left_q;
    phase_d  = phase_q;
    gather_d = gather_q;
    gidx_d   = gidx_q;
    words_d  = words_q;
    halted_d = halted_q;
    cap_d    = cfg_we_i ? cfg_wdata_i : cap_q;
    p        = '0;
    step1    = 1'b0;
    delta_a  = '0;
    oor_a    = 1'b0;
    oor_b    = 1'b0;
    need     = 2'd0;
    st       = ST_OK;

    if (accept && !halted_q) begin
      case (phase_q)
        PH_HEADER, PH_COUNT: begin
          if (phase_q == PH_HEADER) begin
            rtype_d = rec_type_e'(b[7:5]);
            if (b[4:0] == 5'd0) begin
              phase_d = PH_COUNT;
            end
          end
          if (start) begin
            if (over) begin
              p.n      = 2'd1;
              p.r0     = '{value: '0, repeat_res: '0, status: ST_CAP, end_of_stream: 1'b0};
              halted_d = 1'b1;
              phase_d  = PH_HEADER;
            end else if (st_type == RT_OOR || st_type == RT_ZERO) begin
              p.n     = 2'd1;
              p.r0    = '{value: (st_type == RT_ZERO) ? rv_q : OutWord, repeat_res: cnt,
                          status: ST_OK, end_of_stream: 1'b0};
              words_d = wsum[COUNT_WIDTH-1:0];
              phase_d = PH_HEADER;
            end else begin
              left_d   = cnt;
              gidx_d   = 2'd0;
              gather_d = '0;
              phase_d  = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          case (rtype_q)
            RT_D4: begin
              step1   = 1'b1;
              delta_a = sx4(b[3:0]);
              oor_a   = b[3:0] == 4'h8;
              oor_b   = b[7:4] == 4'h8;
            end
            RT_D8: begin
              step1   = 1'b1;
              delta_a = sx8(b);
              oor_a   = b == 8'h80;
            end
            RT_D12: begin
              if (gidx_q == 2'd0) begin
                gather_d = {16'd0, b};
                gidx_d   = 2'd1;
              end else begin
                step1   = 1'b1;
                delta_a = sx12(code12);
                oor_a   = code12 == 12'h800;
                if (gidx_q == 2'd1) begin
                  gather_d = {8'd0, b, gather_q[7:0]};
                  gidx_d   = 2'd2;
                end else begin
                  gidx_d = 2'd0;
                end
              end
            end
            RT_D16, RT_D24, RT_D32: begin
              case (rtype_q)
                RT_D16:  need = 2'd1;
                RT_D24:  need = 2'd2;
                default: need = 2'd3;
              endcase
              if (gidx_q < need) begin
                case (gidx_q)
                  2'd0:    gather_d = {16'd0, b};
                  2'd1:    gather_d = gather_q | {8'd0, b, 8'd0};
                  default: gather_d = gather_q | {b, 16'd0};
                endcase
                gidx_d = gidx_q + 2'd1;
              end else begin
                step1  = 1'b1;
                gidx_d = 2'd0;
                case (rtype_q)
                  RT_D16: begin
                    delta_a = sx16({b, gather_q[7:0]});
                    oor_a   = {b, gather_q[7:0]} == 16'h8000;
                  end
                  RT_D24: begin
                    delta_a = sx24({b, gather_q[15:0]});
                    oor_a   = {b, gather_q[15:0]} == 24'h80_0000;
                  end
                  default: begin
                    delta_a = (({b, gather_q} == OutWord)) ? '0 : {b, gather_q};
                    oor_a   = {b, gather_q} == OutWord;
                  end
                endcase
              end
            end
            default: ;
          endcase

          if (step1) begin
            p.n  = 2'd1;
            p.r0 = '{value: oor_a ? OutWord : sum_a, repeat_res: 9'd1, status: ST_OK,
                     end_of_stream: 1'b0};
            rv_d = sum_a;
            if (left1 == 9'd0) begin
              left_d  = '0;
              words_d = words_q + COUNT_WIDTH'(1);
              phase_d = PH_HEADER;
              gidx_d  = 2'd0;
            end else if (rtype_q == RT_D4) begin
              p.n     = 2'd2;
              p.r1    = '{value: oor_b ? OutWord : sum_b, repeat_res: 9'd1, status: ST_OK,
                          end_of_stream: 1'b0};
              rv_d    = sum_b;
              left_d  = left_q - 9'd2;
              words_d = words_q + COUNT_WIDTH'(2);
              if (left_q == 9'd2) begin
                phase_d = PH_HEADER;
                gidx_d  = 2'd0;
              end
            end else begin
              left_d  = left1;
              words_d = words_q + COUNT_WIDTH'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (accept && in_i.last_byte) begin
      if (halted_d) begin
        st = ST_CAP;
      end else if (phase_d != PH_HEADER) begin
        st = ST_TRUNC;
      end else begin
        st = ST_OK;
      end
      if (p.n == 2'd0) begin
        p.n  = 2'd1;
        p.r0 = '{value: '0, repeat_res: '0, status: st, end_of_stream: 1'b1};
      end else if (p.n == 2'd1) begin
        if (st == ST_TRUNC) p.r0.status = ST_TRUNC;
        p.r0.end_of_stream = 1'b1;
      end else begin
        if (st == ST_TRUNC) p.r1.status = ST_TRUNC;
        p.r1.end_of_stream = 1'b1;
      end
      // next byte opens a fresh stream
      rv_d     = '0;
      rtype_d  = RT_OOR;
      left_d   = '0;
      phase_d  = PH_HEADER;
      gather_d = '0;
      gidx_d   = 2'd0;
      words_d  = '0;
      halted_d = 1'b0;
    end
  end

  assign push_o = p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= '0;
      rtype_q  <= RT_OOR;
      left_q   <= '0;
      phase_q  <= PH_HEADER;
      gather_q <= '0;
      gidx_q   <= '0;
      words_q  <= '0;
      halted_q <= 1'b0;
      cap_q    <= CapReset;
    end else begin
      rv_q     <= rv_d;
      rtype_q  <= rtype_d;
      left_q   <= left_d;
      phase_q  <= phase_d;
      gather_q <= gather_d;
      gidx_q   <= gidx_d;
      words_q  <= words_d;
      halted_q <= halted_d;
      cap_q    <= cap_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/drd_queue.sv =====
`default_nettype none
module drd_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  drd_pkg::push_t  push_i,
  input  wire             pop_i,
  output drd_pkg::res_t   head_o,
  output logic            avail_o,
  output logic            room_o
);
  import drd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  res_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_q + PtrW'(1);
  assign wr_d    = wr_q + PtrW'(push_i.n);
  assign rd_d    = rd_q + PtrW'(pop_i);
  assign cnt_d   = cnt_q + CntW'(push_i.n) - CntW'(pop_i);

  assign head_o  = mem_q[rd_q];
  assign avail_o = cnt_q != '0;
  // a byte may push two words
  assign room_o  = cnt_q <= CntW'(QueueDepth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_next] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/drd_out.sv =====
`default_nettype none
module drd_out (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  drd_pkg::res_t  head_i,
  input  wire            avail_i,
  output logic           pop_o,
  drd_out_if.source      out_o
);
  import drd_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign pop_o   = avail_i & (~valid_q | out_o.ready);
  assign valid_d = pop_o | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.value         = data_q.value;
  assign out_o.repeat_res    = data_q.repeat_res;
  assign out_o.status        = data_q.status;
  assign out_o.end_of_stream = data_q.end_of_stream;

endmodule
`default_nettype wire

// ===== sv/delta_record_dem_decoder.sv =====
// Delta-record elevation decoder. Takes one stream byte per cycle; a byte is
// accepted whenever the four-word result queue has room for two words, so a
// steady stream runs at one byte per clock while the outputs take every word.
// Records of 4-bit differences give two words per byte, so the queue fills and
// holds back bytes, as the single output register hands out one word per cycle.
// A word passes two registers: the queue entry, written when its byte is
// accepted, then the output register, loaded once empty or its word is taken.
// Write out_capacity only while no stream byte is in flight and the outputs
// have drained; there is no read-back and no clearing pass after reset.
`default_nettype none
module delta_record_dem_decoder #(
  parameter int COUNT_WIDTH = drd_pkg::CountWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [drd_pkg::CapWidth-1:0]  cfg_wdata_i,
  drd_in_if.sink                       in_i,
  drd_out_if.source                    out_o
);
  import drd_pkg::*;

  push_t push;
  res_t  head;
  logic  avail;
  logic  room;
  logic  pop;

  drd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .room_i      (room),
    .in_i        (in_i),
    .push_o      (push)
  );

  drd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .avail_o (avail),
    .room_o  (room)
  );

  drd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (avail),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
